// ===== hw/rtl/panel_bus_snoop_and_key_inject_top_defines.svh =====
// assertion macros shared by the panel bus snoop checker
`ifndef PANEL_BUS_SNOOP_AND_KEY_INJECT_TOP_DEFINES_SVH
`define PANEL_BUS_SNOOP_AND_KEY_INJECT_TOP_DEFINES_SVH

// concurrent assertion on a given clock, masked while reset is low
`define PBSK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// same, on the block clock and reset
`define PBSK_ASSERT_CLK(lbl, prop, msg) \
  `PBSK_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hw/rtl/pbsk_pkg.sv =====
// types and constants of the panel bus snoop and key inject block
package pbsk_pkg;

  localparam int unsigned PayloadBytes   = 5;
  localparam int unsigned ReplyFrameBits = 10;
  localparam int unsigned FieldBytes     = 5;
  localparam int unsigned PayloadFieldW  = 8 * FieldBytes;
  localparam int unsigned PackBytes      =
    (PayloadBytes < FieldBytes) ? PayloadBytes : FieldBytes;

  localparam int unsigned CntW     = 16;
  localparam int unsigned ByteIdxW = CntW - 3;
  localparam int unsigned PosW     = 4;

  localparam logic [7:0]      StopBitsHigh = 8'hFE;
  localparam logic [1:0]      BrightForm   = 2'b10;
  localparam logic [CntW-1:0] BrightBit    = CntW'(7);
  localparam logic [CntW-1:0] CntMax       = '1;
  localparam logic [PosW-1:0] PosLast      = PosW'(ReplyFrameBits - 1);

  typedef enum logic {
    OP_STROBE = 1'b0,
    OP_CLOCK  = 1'b1
  } op_e;

  typedef struct packed {
    logic       operation;
    logic       clk_level;
    logic       strobe_level;
    logic [7:0] key_code;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic                     reply_bit;
    logic                     reply_valid;
    logic                     frame_boundary;
    logic                     packet_ready;
    logic [7:0]               command_seen;
    logic [PayloadFieldW-1:0] payload_bytes;
    logic [7:0]               brightness_seen;
  } result_t;

endpackage

// ===== hw/rtl/pbsk_in_if.sv =====
// input channel: one pin-change event per transfer
interface pbsk_in_if import pbsk_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       operation;
  logic       clk_level;
  logic       strobe_level;
  logic [7:0] key_code;

  modport source(output valid, operation, clk_level, strobe_level, key_code, input ready);
  modport sink(input valid, operation, clk_level, strobe_level, key_code, output ready);
endinterface

// ===== hw/rtl/pbsk_out_if.sv =====
// output channel: one snoop result per transfer
interface pbsk_out_if import pbsk_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     reply_bit;
  logic                     reply_valid;
  logic                     frame_boundary;
  logic                     packet_ready;
  logic [7:0]               command_seen;
  logic [PayloadFieldW-1:0] payload_bytes;
  logic [7:0]               brightness_seen;

  modport source(output valid, reply_bit, reply_valid, frame_boundary, packet_ready,
                 command_seen, payload_bytes, brightness_seen, input ready);
  modport sink(input valid, reply_bit, reply_valid, frame_boundary, packet_ready,
               command_seen, payload_bytes, brightness_seen, output ready);
endinterface

// ===== hw/rtl/pbsk_in_reg.sv =====
// input register stage for pin-change events
module pbsk_in_reg import pbsk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pbsk_in_if.sink    in_i,
  input  logic       take_i,
  output stage_t     stage_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = 1'b1;
      item_d  = '{operation:    in_i.operation,
                  clk_level:    in_i.clk_level,
                  strobe_level: in_i.strobe_level,
                  key_code:     in_i.key_code};
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign stage_o = '{valid: valid_q, item: item_q};

endmodule

// ===== hw/rtl/pbsk_engine.sv =====
// bus state update, reply bit selection and result register
module pbsk_engine import pbsk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  stage_t     stage_i,
  output logic       take_o,
  pbsk_out_if.source out_o
);

  logic [7:0]      pay_cmd_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [7:0]      bright_q, bright_d;
  logic [7:0]      pay_q [PayloadBytes];
  logic [7:0]      pay_d [PayloadBytes];
  logic            out_valid_q;
  result_t         res_q, res_d;

  logic [ByteIdxW-1:0] byte_idx;
  logic [2:0]          bit_idx;
  logic [15:0]         frame;
  item_t               it;

  assign take_o   = stage_i.valid && (!out_valid_q || out_o.ready);
  assign it       = stage_i.item;
  assign byte_idx = cnt_q[CntW-1:3];
  assign bit_idx  = cnt_q[2:0];
  // start bit, key code, then ones
  assign frame    = {StopBitsHigh[7:1], it.key_code, 1'b0};

  always_comb begin
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    cmd_d    = cmd_q;
    bright_d = bright_q;
    pay_d    = pay_q;
    res_d    = '0;
    res_d.reply_bit = 1'b1;

    unique case (op_e'(it.operation))
      OP_STROBE: begin
        if (it.clk_level) begin
          cnt_d = '0;
          pos_d = '0;
          cmd_d = '0;
          res_d.frame_boundary = 1'b1;
          res_d.packet_ready   = it.strobe_level;
        end
      end
      OP_CLOCK: begin
        if (it.clk_level) begin
          if (byte_idx == '0) begin
            cmd_d = cmd_q | (8'(it.strobe_level) << bit_idx);
          end else if (cmd_q == pay_cmd_q) begin
            for (int i = 0; i < PayloadBytes; i++) begin
              if (byte_idx == ByteIdxW'(i + 1)) begin
                pay_d[i][bit_idx] = it.strobe_level;
              end
            end
          end
          if (cnt_q == BrightBit && cmd_d[7:6] == BrightForm) begin
            bright_d = cmd_d;
          end
          cnt_d = cnt_q + CntW'(1);
          // mod-10 shadow of the counter, also restarts on counter wrap
          if (cnt_q == CntMax || pos_q == PosLast) begin
            pos_d = '0;
          end else begin
            pos_d = pos_q + PosW'(1);
          end
        end else begin
          res_d.reply_valid = 1'b1;
          res_d.reply_bit   = frame[pos_q];
        end
      end
      default: ;
    endcase

    res_d.command_seen    = cmd_d;
    res_d.brightness_seen = bright_d;
    for (int i = 0; i < PackBytes; i++) begin
      res_d.payload_bytes[8*i +: 8] = pay_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pay_cmd_q   <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      cmd_q       <= '0;
      bright_q    <= '0;
      pay_q       <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pay_cmd_q <= cfg_wdata_i;
      end
      if (take_o) begin
        cnt_q       <= cnt_d;
        pos_q       <= pos_d;
        cmd_q       <= cmd_d;
        bright_q    <= bright_d;
        pay_q       <= pay_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.reply_bit       = res_q.reply_bit;
  assign out_o.reply_valid     = res_q.reply_valid;
  assign out_o.frame_boundary  = res_q.frame_boundary;
  assign out_o.packet_ready    = res_q.packet_ready;
  assign out_o.command_seen    = res_q.command_seen;
  assign out_o.payload_bytes   = res_q.payload_bytes;
  assign out_o.brightness_seen = res_q.brightness_seen;

endmodule

// ===== hw/rtl/panel_bus_snoop_and_key_inject_top.sv =====
// top level of the panel bus snoop and key inject block
//
//  port          direction  transfer
//  in_i          sink       one pin-change event (operation, levels, key code)
//  out_o         source     one result per event (reply bit, flags, bytes)
//  cfg_we_i/...  write      payload command byte, taken on any rising clock edge with cfg_we_i
//
// sustained rate is one event per cycle while out_o.ready stays high; an input transfer
// reaches the result through the input register and then the result register
// reset clears counters, command, brightness, payload and the config byte at once,
// so events are taken from the first cycle after reset with no clearing pass
// the input register still takes an event while a result waits on out_o; when
// both registers are full in_i.ready drops until out_o.ready frees the result
module panel_bus_snoop_and_key_inject_top import pbsk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  pbsk_in_if.sink    in_i,
  pbsk_out_if.source out_o
);

  // stage handshake between the input register and the engine
  stage_t stage;
  logic   take;

  // event capture
  pbsk_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .stage_o (stage)
  );

  // state update, reply framing and result register
  pbsk_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stage_i     (stage),
    .take_o      (take),
    .out_o       (out_o)
  );

endmodule

// ===== hw/rtl/pbsk_checker.sv =====
// port-level checks on the snoop results, bound to the top level
`include "panel_bus_snoop_and_key_inject_top_defines.svh"

module pbsk_checker import pbsk_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic                     reply_bit_i,
  input logic                     reply_valid_i,
  input logic                     frame_boundary_i,
  input logic                     packet_ready_i,
  input logic [7:0]               command_seen_i,
  input logic [PayloadFieldW-1:0] payload_bytes_i
);

  // idle reply line when no reply is due
  `PBSK_ASSERT_CLK(a_reply_idle, out_valid_i && !reply_valid_i |-> reply_bit_i, "reply bit not idle")

  // a reply slot and a frame boundary never come from the same event
  `PBSK_ASSERT_CLK(a_reply_no_boundary, out_valid_i && reply_valid_i |-> !frame_boundary_i, "reply on boundary")

  // packet end is only flagged at a boundary
  `PBSK_ASSERT_CLK(a_ready_at_boundary, out_valid_i && packet_ready_i |-> frame_boundary_i, "packet ready off boundary")

  // a boundary restarts the command byte
  `PBSK_ASSERT_CLK(a_boundary_clears_cmd, out_valid_i && frame_boundary_i |-> command_seen_i == 8'h00, "command not cleared")

  // stalled result holds
  `PBSK_ASSERT_CLK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(payload_bytes_i), "result dropped")

endmodule

bind panel_bus_snoop_and_key_inject_top pbsk_checker u_pbsk_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .reply_bit_i      (out_o.reply_bit),
  .reply_valid_i    (out_o.reply_valid),
  .frame_boundary_i (out_o.frame_boundary),
  .packet_ready_i   (out_o.packet_ready),
  .command_seen_i   (out_o.command_seen),
  .payload_bytes_i  (out_o.payload_bytes)
);

// ===== tb/sv/pbsk_snoop_checker.sv =====
// checker for the panel bus snoop block: predicts each result and compares it field by field
module pbsk_snoop_checker import pbsk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  pbsk_in_if          ev_mon,
  pbsk_out_if         res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // shadow of the snoop state
  logic [CntW-1:0] bit_cnt;
  logic [7:0]      cmd_byte;
  logic [7:0]      pay_store [PayloadBytes];
  logic [7:0]      bright_byte;
  logic [7:0]      match_cmd;

  result_t snoop_results_due [$];

  // one pin event: update the shadow state and return the result it causes
  function automatic result_t snoop_event(item_t ev);
    result_t         r;
    logic [15:0]     frame;
    logic [ByteIdxW-1:0] byte_idx;
    logic [2:0]      bit_idx;
    int unsigned     pos;
    r = '0;
    r.reply_bit = 1'b1;
    if (ev.operation == OP_STROBE) begin
      // strobe moves while clock high: frame boundary
      if (ev.clk_level) begin
        bit_cnt = '0;
        cmd_byte = '0;
        r.frame_boundary = 1'b1;
        r.packet_ready = ev.strobe_level;
      end
    end else if (ev.clk_level) begin
      byte_idx = bit_cnt[CntW-1:3];
      bit_idx = bit_cnt[2:0];
      if (byte_idx == '0) begin
        cmd_byte[bit_idx] = cmd_byte[bit_idx] | ev.strobe_level;
      end else if (byte_idx <= PayloadBytes && cmd_byte == match_cmd) begin
        pay_store[byte_idx - 1][bit_idx] = ev.strobe_level;
      end
      if (bit_cnt == BrightBit && cmd_byte[7:6] == BrightForm) begin
        bright_byte = cmd_byte;
      end
      bit_cnt = bit_cnt + 1'b1;
    end else begin
      // reply frame: start bit 0, key code, then ones
      frame = {StopBitsHigh, 8'h00} | {7'h00, ev.key_code, 1'b0};
      pos = bit_cnt % ReplyFrameBits;
      r.reply_bit = frame[pos];
      r.reply_valid = 1'b1;
    end
    r.command_seen = cmd_byte;
    for (int i = 0; i < PackBytes; i++) begin
      r.payload_bytes[8*i +: 8] = pay_store[i];
    end
    r.brightness_seen = bright_byte;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [39:0] want,
                             input logic [39:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   ev;
    result_t want;
    if (!rst_ni) begin
      bit_cnt = '0;
      cmd_byte = '0;
      bright_byte = '0;
      match_cmd = '0;
      for (int i = 0; i < PayloadBytes; i++) pay_store[i] = '0;
      snoop_results_due.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        match_cmd = cfg_wdata_i;
      end
      // results first, so a result never meets its own event
      if (res_mon.valid && res_mon.ready) begin
        if (snoop_results_due.size() == 0) begin
          $error("result transfer with no event outstanding");
          fail_count_o++;
        end else begin
          want = snoop_results_due.pop_front();
          check_field("reply_bit", want.reply_bit, res_mon.reply_bit);
          check_field("reply_valid", want.reply_valid, res_mon.reply_valid);
          check_field("frame_boundary", want.frame_boundary, res_mon.frame_boundary);
          check_field("packet_ready", want.packet_ready, res_mon.packet_ready);
          check_field("command_seen", want.command_seen, res_mon.command_seen);
          check_field("payload_bytes", want.payload_bytes, res_mon.payload_bytes);
          check_field("brightness_seen", want.brightness_seen, res_mon.brightness_seen);
        end
      end
      if (ev_mon.valid && ev_mon.ready) begin
        ev.operation = ev_mon.operation;
        ev.clk_level = ev_mon.clk_level;
        ev.strobe_level = ev_mon.strobe_level;
        ev.key_code = ev_mon.key_code;
        snoop_results_due.push_back(snoop_event(ev));
      end
      pending_o = snoop_results_due.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench top: stimulus and verdict for the panel bus snoop and key inject block
module tb_top import pbsk_pkg::*; ();

  // input transfers to send before the verdict, a frame may run a little past it
  localparam int unsigned ItemBudget = 520;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned pending;

  // idle chance in percent, shared by the event sender and the result taker
  int unsigned idle_pct;
  // input transfers sent so far
  int unsigned events_sent;
  // payload command currently programmed
  logic [7:0]  match_cmd;

  pbsk_in_if  ev_if ();
  pbsk_out_if res_if ();

  panel_bus_snoop_and_key_inject_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (ev_if),
    .out_o       (res_if)
  );

  pbsk_snoop_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .ev_mon       (ev_if),
    .res_mon      (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock, period 2
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // result side stalls at random; idle_pct of zero gives a stall-free stretch
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= idle_pct);
  end

  // one event transfer; valid stays high after acceptance so back-to-back
  // transfers never see valid lowered and raised in the same step
  task automatic send_event(input op_e op, input logic clk_lvl, input logic sd,
                            input logic [7:0] key);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      ev_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    ev_if.valid        <= 1'b1;
    ev_if.operation    <= op;
    ev_if.clk_level    <= clk_lvl;
    ev_if.strobe_level <= sd;
    ev_if.key_code     <= key;
    @(posedge clk_i);
    while (!ev_if.ready) @(posedge clk_i);
    events_sent++;
  endtask

  // stop sending and wait until every result has been taken, plus the
  // input and result registers and some margin
  task automatic drain;
    @(negedge clk_i);
    ev_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // program the payload command, only with the block idle
  task automatic write_match(input logic [7:0] value);
    drain();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    match_cmd = value;
  endtask

  // one bus frame: boundary, command byte LSB first, then payload bits;
  // reply_pct sets how often a falling clock (reply slot) follows a bit
  task automatic run_frame(input logic [7:0] cmd, input int unsigned nbits,
                           input int unsigned reply_pct);
    logic [63:0] data;
    logic [7:0]  key;
    data = {$urandom, $urandom};
    data[7:0] = cmd;
    key = 8'($urandom);
    // frame start: strobe drops while clock is high
    send_event(OP_STROBE, 1'b1, 1'b0, key);
    for (int unsigned i = 0; i < nbits; i++) begin
      // noise: strobe wiggles while clock low, ignored by the block
      if ($urandom_range(19) == 0) send_event(OP_STROBE, 1'b0, 1'($urandom), key);
      // broken frame: a stray boundary in the middle
      if ($urandom_range(199) == 0) send_event(OP_STROBE, 1'b1, 1'($urandom), key);
      send_event(OP_CLOCK, 1'b1, data[i % 64], key);
      if ($urandom_range(99) < reply_pct) begin
        if ($urandom_range(9) == 0) key = 8'($urandom);
        send_event(OP_CLOCK, 1'b0, 1'($urandom), key);
      end
    end
    // packet end: strobe rises while clock is high
    if ($urandom_range(3) != 0) send_event(OP_STROBE, 1'b1, 1'b1, key);
  endtask

  // run limit, far above the slowest correct run
  initial begin
    #1600000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned phase;
    logic [7:0]  cmd;
    int unsigned nbits;

    // every input known from time zero
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = 8'h00;
    ev_if.valid        = 1'b0;
    ev_if.operation    = OP_STROBE;
    ev_if.clk_level    = 1'b0;
    ev_if.strobe_level = 1'b0;
    ev_if.key_code     = 8'h00;
    res_if.ready       = 1'b0;
    idle_pct           = 17;
    events_sent        = 0;
    match_cmd          = 8'h00;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, payload command 0xB1 (also of brightness form)
    write_match(8'hB1);
    send_event(OP_STROBE, 1'b0, 1'b1, 8'h00);  // strobe move, clock low: nothing
    send_event(OP_STROBE, 1'b1, 1'b1, 8'h00);  // boundary, packet ended
    send_event(OP_STROBE, 1'b1, 1'b0, 8'hFF);  // boundary, packet starts
    // command 0xB1, LSB first
    send_event(OP_CLOCK, 1'b1, 1'b1, 8'h00);
    send_event(OP_CLOCK, 1'b1, 1'b0, 8'h00);
    send_event(OP_CLOCK, 1'b1, 1'b0, 8'h00);
    send_event(OP_CLOCK, 1'b1, 1'b0, 8'h00);
    send_event(OP_CLOCK, 1'b1, 1'b1, 8'h00);
    send_event(OP_CLOCK, 1'b1, 1'b1, 8'h00);
    send_event(OP_CLOCK, 1'b1, 1'b0, 8'h00);
    send_event(OP_CLOCK, 1'b1, 1'b1, 8'h00);   // bit 7: brightness latch
    send_event(OP_CLOCK, 1'b0, 1'b0, 8'h00);   // reply slot with key 0x00
    // first payload bits, command matches
    send_event(OP_CLOCK, 1'b1, 1'b1, 8'hFF);
    send_event(OP_CLOCK, 1'b1, 1'b0, 8'hFF);
    send_event(OP_CLOCK, 1'b1, 1'b1, 8'hFF);
    send_event(OP_CLOCK, 1'b1, 1'b1, 8'hFF);
    send_event(OP_CLOCK, 1'b0, 1'b1, 8'hFF);   // reply slot with key 0xFF
    send_event(OP_CLOCK, 1'b0, 1'b0, 8'h80);   // same slot, key 0x80
    send_event(OP_STROBE, 1'b0, 1'b0, 8'h80);  // ignored
    send_event(OP_STROBE, 1'b1, 1'b1, 8'h7F);  // packet ended

    // random part: phases of frames, each phase behind a config write
    phase = 0;
    while (events_sent < ItemBudget) begin
      case (phase)
        0: begin
          write_match(8'h00);
        end
        1: begin
          write_match(8'hFF);
        end
        default: begin
          write_match(($urandom_range(1) == 0) ? {2'b10, 6'($urandom)} : 8'($urandom));
        end
      endcase
      // first phase runs with no idling on either side
      idle_pct = (phase == 0) ? 0 : 17;
      repeat (4) begin
        if (events_sent >= ItemBudget) break;
        if ($urandom_range(99) < 85) begin
          // mostly the programmed command so payload gets captured
          case ($urandom_range(9))
            0, 1:    cmd = 8'($urandom);
            2:       cmd = {2'b10, 6'($urandom)};
            default: cmd = match_cmd;
          endcase
          // mostly mid-size frames, some short, some past the payload end
          nbits = ($urandom_range(9) == 0) ? $urandom_range(8) : $urandom_range(60, 8);
          run_frame(cmd, nbits, 60);
        end else begin
          // noise burst of arbitrary events
          repeat (8) begin
            send_event(op_e'($urandom_range(1)), 1'($urandom), 1'($urandom),
                       8'($urandom));
          end
        end
      end
      phase++;
    end

    // let everything settle, then the verdict
    idle_pct = 17;
    drain();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
